// ===== hdl/babylonian_square_root_assert.svh =====
// Assertion macros shared by the square root block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BABYLONIAN_SQUARE_ROOT_ASSERT_SVH
`define BABYLONIAN_SQUARE_ROOT_ASSERT_SVH

`ifndef SYNTHESIS

`define BSR_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

`define BSR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`define BSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define BSR_ASSERT(label, expr)
`define BSR_ASSERT_IMPL(label, ante, cons)
`define BSR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/bsr_pkg.sv =====
package bsr_pkg;

  // Field widths.
  localparam int DATA_W   = 32;
  localparam int STEPS_W  = 7;
  localparam int STATUS_W = 2;

  // Defaults for the top-level parameters.
  localparam int MAX_STEPS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Tolerance after reset, about 0.0001 in Q16.16.
  localparam logic [DATA_W-1:0] TOL_RESET = 32'd7;

  // The divider produces one quotient bit per cycle.
  localparam int DIV_ITERS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_CONVERGED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LIMIT      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_GUESS = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                in_ready;
    logic                load;
    logic                div_start;
    logic                sum;
    logic                advance;
    logic                emit;
    logic [STATUS_W-1:0] status;
  } bsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic guess_zero;
    logic div_busy;
    logic converged;
    logic at_limit;
    logic out_free;
  } bsr_sts_t;

endpackage

// ===== hdl/bsr_in_if.sv =====
interface bsr_in_if import bsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;
  logic [DATA_W-1:0] guess;

  modport source (output valid, output value, output guess, input ready);
  modport sink (input valid, input value, input guess, output ready);
endinterface

// ===== hdl/bsr_out_if.sv =====
interface bsr_out_if import bsr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   root;
  logic [STEPS_W-1:0]  steps;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output root, output steps, output status, input ready);
  modport sink (input valid, input root, input steps, input status, output ready);
endinterface

// ===== hdl/bsr_div.sv =====
`include "babylonian_square_root_assert.svh"

// Restoring divider for floor((dividend << FRAC_BITS) / (2 * divisor)).
// One quotient bit per cycle; quotients above 32 bits saturate at once.
module bsr_div import bsr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              busy,
  output logic [DATA_W-1:0] quotient
);

  localparam int SH    = DATA_W + 1 - FRAC_BITS;
  localparam int REM_W = DATA_W + 1;

  logic [REM_W-1:0]       rem;
  logic [DATA_W-1:0]      qsh;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [REM_W-1:0]       den;
  logic [DATA_W+SH-1:0]   sat_limit;
  logic                   saturate;
  logic [REM_W:0]         shifted;
  logic [REM_W:0]         trial;
  logic                   fits;

  // The denominator is twice the current estimate.
  assign den = {divisor, 1'b0};

  // The quotient needs more than 32 bits exactly when dividend >= divisor << SH.
  assign sat_limit = {divisor, {SH{1'b0}}};
  assign saturate  = {{SH{1'b0}}, dividend} >= sat_limit;

  // One trial subtraction per cycle.
  assign shifted = {rem, qsh[DATA_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign fits    = !trial[REM_W];

  // Busy flag and iteration count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= (divisor != '0) && !saturate;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift register. The quotient bits replace the low
  // dividend bits as they are shifted out.
  always_ff @(posedge clk) begin
    if (start) begin
      if (divisor == '0) begin
        qsh <= '0;
        rem <= '0;
      end else if (saturate) begin
        qsh <= '1;
        rem <= '0;
      end else begin
        rem <= {{(REM_W - FRAC_BITS){1'b0}}, dividend[DATA_W-1:DATA_W-FRAC_BITS]};
        qsh <= {dividend[DATA_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      end
    end else if (busy) begin
      rem <= fits ? trial[REM_W-1:0] : shifted[REM_W-1:0];
      qsh <= {qsh[DATA_W-2:0], fits};
    end
  end

  assign quotient = qsh;

  // While the divider is busy, the partial remainder stays below the denominator.
  `BSR_ASSERT_IMPL(a_rem_bound, busy, rem < den)

endmodule

// ===== hdl/bsr_dp.sv =====
`include "babylonian_square_root_assert.svh"

// Datapath: operand and estimate registers, tolerance register, one
// Babylonian step built around the divider, and the result register.
module bsr_dp import bsr_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bsr_cmd_t          cmd,
  output bsr_sts_t          sts,
  bsr_in_if.sink            in_ch,
  bsr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata
);

  logic [DATA_W-1:0]   tolerance;
  logic [DATA_W-1:0]   a_val;
  logic [DATA_W-1:0]   r_est;
  logic [DATA_W-1:0]   x_est;
  logic [STEPS_W-1:0]  n;
  logic                out_valid;
  logic [DATA_W-1:0]   root;
  logic [STEPS_W-1:0]  steps;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   quo;
  logic                div_busy;
  logic [DATA_W:0]     sum_wide;
  logic [DATA_W-1:0]   x_next;
  logic [DATA_W-1:0]   diff;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  // Quotient unit for the A/(2r) term.
  bsr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (a_val),
    .divisor  (r_est),
    .busy     (div_busy),
    .quotient (quo)
  );

  // New estimate r/2 + A/(2r), saturated to 32 bits.
  assign sum_wide = {2'b00, r_est[DATA_W-1:1]} + {1'b0, quo};
  assign x_next   = sum_wide[DATA_W] ? '1 : sum_wide[DATA_W-1:0];

  // Change between the new and previous estimate.
  assign diff = (x_est >= r_est) ? (x_est - r_est) : (r_est - x_est);

  // Operand, estimate and step count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cmd.load) begin
      n <= '0;
    end else if (cmd.sum) begin
      n <= n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_val <= in_ch.value;
      r_est <= in_ch.guess;
      x_est <= '0;
    end else begin
      if (cmd.sum) begin
        x_est <= x_next;
      end
      if (cmd.advance) begin
        r_est <= x_est;
      end
    end
  end

  // Result register; it frees as soon as the sink takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      root   <= x_est;
      steps  <= n;
      status <= cmd.status;
    end
  end

  assign in_ch.ready   = cmd.in_ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.root   = root;
  assign out_ch.steps  = steps;
  assign out_ch.status = status;

  // Status back to the controller.
  always_comb begin
    sts.in_valid   = in_ch.valid;
    sts.guess_zero = (r_est == '0);
    sts.div_busy   = div_busy;
    sts.converged  = diff < tolerance;
    sts.at_limit   = (n == STEPS_W'(MAX_STEPS));
    sts.out_free   = !out_valid || out_ch.ready;
  end

  // The step count never runs past the iteration cap.
  `BSR_ASSERT(a_step_bound, n <= STEPS_W'(MAX_STEPS))
  // A zero guess produces a zero root after no steps.
  `BSR_ASSERT_NEXT(a_zero_guess, cmd.emit && cmd.status == ST_ZERO_GUESS, root == '0 && steps == '0)

endmodule

// ===== hdl/bsr_ctrl.sv =====
// Controller: sequences the load, the divide, the sum and the convergence
// check of each step, and hands the finished result to the output register.
module bsr_ctrl import bsr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  bsr_sts_t sts,
  output bsr_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [STATUS_W-1:0] result_status;
  logic [STATUS_W-1:0] result_status_next;

  // State and result status registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_status <= ST_CONVERGED;
    end else begin
      state         <= state_next;
      result_status <= result_status_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next         = state;
    result_status_next = result_status;
    cmd                = '0;
    cmd.status         = result_status;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.guess_zero) begin
          result_status_next = ST_ZERO_GUESS;
          state_next         = S_DONE;
        end else begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.converged) begin
          result_status_next = ST_CONVERGED;
          state_next         = S_DONE;
        end else if (sts.at_limit) begin
          result_status_next = ST_LIMIT;
          state_next         = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_INIT;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/babylonian_square_root.sv =====
// Each Babylonian step starts the divider, waits out its bit-serial divide, then
// sums and checks convergence; a step whose quotient saturates skips the divide.
// Throughput: one item at a time; the next item is taken once the current
// result sits in the output register, which may still be waiting on the sink.
// Reset (rst, synchronous, active high) idles the controller, empties the
// output register and sets the tolerance to 7.
module babylonian_square_root import bsr_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  bsr_in_if.sink            in_ch,
  bsr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata
);

  bsr_cmd_t cmd;
  bsr_sts_t sts;

  // Step sequencer.
  bsr_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Arithmetic and result registers.
  bsr_dp #(
    .MAX_STEPS (MAX_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ===== sim/babylonian_square_root_tb.sv =====
`timescale 1ns / 1ps

module babylonian_square_root_tb;
  import bsr_pkg::*;

  // One expected result beat.
  typedef struct packed {
    logic [DATA_W-1:0]   root;
    logic [STEPS_W-1:0]  steps;
    logic [STATUS_W-1:0] status;
  } sqrt_result_t;

  // Tracks the tolerance setting and the queue of predicted roots.
  class sqrt_scoreboard;
    logic [DATA_W-1:0]  tolerance;
    logic [DATA_W-1:0]  estimate;
    logic [STEPS_W-1:0] step_count;
    sqrt_result_t       expected_roots[$];
    int                 errors;

    function new();
      tolerance  = TOL_RESET;
      estimate   = '0;
      step_count = '0;
      errors     = 0;
    endfunction

    // Runs the Newton iteration on the current tolerance.
    function sqrt_result_t predict(input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] guess);
      sqrt_result_t      res;
      logic [DATA_W-1:0] r;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] change;
      logic [63:0]       half;
      logic [63:0]       quo;
      logic [63:0]       total;
      int                n;
      res.status = ST_ZERO_GUESS;
      x = '0;
      n = 0;
      r = guess;
      if (guess != '0) begin
        res.status = ST_LIMIT;
        while (n < MAX_STEPS_DEF) begin
          half = {32'd0, r >> 1};
          quo  = 64'd0;
          // A zero estimate can only arise from a zero value; its quotient is taken as zero.
          if (r != '0) begin
            quo = ({32'd0, value} << FRAC_BITS_DEF) / ({32'd0, r} << 1);
            if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
          end
          total = half + quo;
          if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
          x = total[DATA_W-1:0];
          n++;
          change = (x >= r) ? x - r : r - x;
          if (change < tolerance) begin
            res.status = ST_CONVERGED;
            break;
          end
          r = x;
        end
      end
      res.root  = x;
      res.steps = n[STEPS_W-1:0];
      return res;
    endfunction

    function void note_input(input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] guess);
      sqrt_result_t res;
      res = predict(value, guess);
      estimate   = res.root;
      step_count = res.steps;
      expected_roots.push_back(res);
    endfunction

    function void check_result(input logic [DATA_W-1:0] root, input logic [STEPS_W-1:0] steps,
                               input logic [STATUS_W-1:0] status);
      sqrt_result_t exp_res;
      if (expected_roots.size() == 0) begin
        $error("unexpected result beat: root %h steps %0d status %0d", root, steps, status);
        errors++;
        return;
      end
      exp_res = expected_roots.pop_front();
      if (root !== exp_res.root) begin
        $error("root mismatch: expected %h, actual %h", exp_res.root, root);
        errors++;
      end
      if (steps !== exp_res.steps) begin
        $error("steps mismatch: expected %0d, actual %0d", exp_res.steps, steps);
        errors++;
      end
      if (status !== exp_res.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_roots.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [DATA_W-1:0] cfg_wdata;
  bit                idle_on;

  bsr_in_if  in_ch();
  bsr_out_if out_ch();

  sqrt_scoreboard sb = new();

  babylonian_square_root u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog in case the block hangs.
  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Record accepted inputs and check accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.value, in_ch.guess);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.root, out_ch.steps, out_ch.status);
    end
  end

  // Result sink with bursts of backpressure and quiet stretches in between.
  initial begin
    int stall_left;
    int quiet_left;
    stall_left   = 0;
    quiet_left   = 0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (quiet_left > 0) begin
        out_ch.ready = 1'b1;
        quiet_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        stall_left   = $urandom_range(0, 2);
      end else begin
        out_ch.ready = 1'b1;
        if ($urandom_range(0, 63) == 0) quiet_left = $urandom_range(20, 200);
      end
      @(negedge clk);
    end
  end

  // Present one operand beat, with an optional gap first, and wait for it to be taken.
  task automatic send_operands(input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] guess);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.value = value;
    in_ch.guess = guess;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Change the tolerance once every outstanding root has come back.
  task automatic write_tolerance(input logic [DATA_W-1:0] tol);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = tol;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.tolerance = tol;
  endtask

  // Mostly guesses near the true root, plus wild, tiny and zero guesses.
  task automatic pick_operands(output logic [DATA_W-1:0] value, output logic [DATA_W-1:0] guess);
    int  kind;
    int  center;
    int  spread;
    int  g;
    real rt;
    value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom;
    kind  = $urandom_range(0, 19);
    if (kind == 0) begin
      guess = '0;
    end else if (kind <= 4) begin
      guess = $urandom;
    end else if (kind <= 6) begin
      guess = $urandom_range(1, 255);
    end else if (kind == 7) begin
      guess = (value == '0) ? 32'd1 : value;
    end else begin
      rt     = $sqrt(real'(value)) * 256.0;
      center = int'(rt);
      spread = center / 4 + 8;
      g      = center + $urandom_range(0, 2 * spread) - spread;
      if (g < 1) g = 1;
      guess = g;
    end
  endtask

  task automatic run_random(input logic [DATA_W-1:0] tol, input int count);
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] guess;
    write_tolerance(tol);
    repeat (count) begin
      pick_operands(value, guess);
      send_operands(value, guess);
    end
  endtask

  // Stimulus: directed corners at the reset tolerance, then random phases.
  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    idle_on     = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.guess = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero guesses, zero values, saturating quotients and exact roots.
    send_operands(32'h0000_0000, 32'h0000_0000);
    send_operands(32'hFFFF_FFFF, 32'h0000_0000);
    send_operands(32'h0000_0000, 32'h0000_0001);
    send_operands(32'h0000_0000, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'h0000_0001);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'h0000_0001, 32'h0000_0001);
    send_operands(32'h0000_0001, 32'hFFFF_FFFF);
    send_operands(32'h0001_0000, 32'h0001_0000);
    send_operands(32'h0004_0000, 32'h0001_0000);
    send_operands(32'h0002_0000, 32'h0001_0000);
    send_operands(32'h8000_0000, 32'h00B5_0000);
    send_operands(32'h7FFF_FFFF, 32'h8000_0000);
    send_operands(32'h0000_FFFF, 32'h0000_8000);
    send_operands(32'hFFFF_0000, 32'h00FF_FF00);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);

    // Zero tolerance forces the iteration limit; all-ones stops after one step.
    run_random(32'h0000_0000, 30);
    run_random(32'hFFFF_FFFF, 150);
    run_random(32'h0000_0001, 100);
    run_random(TOL_RESET, 450);
    run_random($urandom_range(2, 4096), 250);
    run_random($urandom, 100);
    run_random(32'h0000_0100, 120);

    // Final stretch at full rate on both sides.
    idle_on = 1'b0;
    run_random(TOL_RESET, 150);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
